[rtl/rbm_pkg.sv]
package rbm_pkg;

  localparam int AddrW    = 13;
  localparam int LocW     = 12;
  localparam int MapW     = 15;
  localparam int DataW    = 8;
  localparam int BankW    = 3;
  localparam int CountW   = 4;
  localparam int RamAddrW = 7;
  localparam int RamBytes = 128;
  localparam int CfgW     = 12;
  localparam int CfgIdxW  = 2;

  localparam logic [LocW-1:0]   NarrowMask = 12'h7ff;
  localparam logic [LocW-1:0]   WideMask   = 12'hfff;
  localparam logic [LocW-1:0]   StrobeMask = 12'hfe0;
  localparam logic [CountW-1:0] MaxBanks   = 4'd8;

  localparam logic OpAccess = 1'b0;
  localparam logic OpLoad   = 1'b1;

  localparam logic [CfgIdxW-1:0] RegNarrowMask  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBankCount   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFirstStrobe = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRamEnable   = 2'd3;

  typedef struct packed {
    logic             op;
    logic             chip_select;
    logic [AddrW-1:0] bus_address;
    logic             read_not_write;
    logic [DataW-1:0] data_in;
    logic [MapW-1:0]  load_index;
  } rbm_in_t;

  typedef struct packed {
    logic             drive_data;
    logic [DataW-1:0] data_out;
    logic [MapW-1:0]  mapped_address;
  } rbm_out_t;

  typedef struct packed {
    logic              narrow_mask;
    logic [CountW-1:0] bank_count;
    logic [LocW-1:0]   first_strobe;
    logic              ram_enable;
  } rbm_cfg_t;

  typedef struct packed {
    logic                rom_we;
    logic                rom_re;
    logic                ram_we;
    logic                ram_re;
    logic                bank_we;
    logic                drive;
    logic [BankW-1:0]    new_bank;
    logic [RamAddrW-1:0] ram_addr;
    logic [MapW-1:0]     mapped;
  } rbm_dec_t;

endpackage

[rtl/rbm_in_if.sv]
interface rbm_in_if import rbm_pkg::*; ();
  logic    valid;
  logic    ready;
  rbm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rbm_out_if.sv]
interface rbm_out_if import rbm_pkg::*; ();
  logic     valid;
  logic     ready;
  rbm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rbm_ram.sv]
module rbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rbm_decode.sv]
module rbm_decode import rbm_pkg::*; #(
  parameter int ROM_BYTES = 32768
) (
  input  logic             valid,
  input  rbm_in_t          req,
  input  rbm_cfg_t         cfg,
  input  logic [BankW-1:0] active_bank,
  output rbm_dec_t         dec
);

  localparam logic [MapW:0] RomLimit = (MapW+1)'(ROM_BYTES);

  logic [LocW-1:0]   a;
  logic [LocW-1:0]   diff;
  logic [CountW-1:0] count;
  logic              access;
  logic              in_w;
  logic              in_r;
  logic              strobe;
  logic [MapW-1:0]   rom_addr;
  logic              rom_read;

  always_comb begin
    a        = req.bus_address[LocW-1:0] & (cfg.narrow_mask ? NarrowMask : WideMask);
    access   = valid && (req.op == OpAccess) && req.chip_select;
    in_w     = cfg.ram_enable && (a < LocW'(RamBytes));
    in_r     = cfg.ram_enable && !in_w && (a < LocW'(2 * RamBytes));
    diff     = a - cfg.first_strobe;
    count    = (cfg.bank_count > MaxBanks) ? MaxBanks : cfg.bank_count;
    strobe   = ((a & StrobeMask) == StrobeMask) && (a >= cfg.first_strobe)
               && (diff < {{(LocW-CountW){1'b0}}, count});
    rom_addr = {active_bank, a};
    rom_read = access && !in_w && !in_r && !strobe && req.read_not_write;

    dec.rom_we   = valid && (req.op == OpLoad) && ({1'b0, req.load_index} < RomLimit);
    dec.rom_re   = rom_read && ({1'b0, rom_addr} < RomLimit);
    dec.ram_we   = access && in_w;
    dec.ram_re   = access && in_r;
    dec.bank_we  = access && !in_w && !in_r && strobe;
    dec.drive    = rom_read || (access && in_r);
    dec.new_bank = diff[BankW-1:0];
    dec.ram_addr = a[RamAddrW-1:0];
    if (!access) begin
      dec.mapped = '0;
    end else if (in_w || in_r || strobe) begin
      dec.mapped = {{(MapW-LocW){1'b0}}, a};
    end else begin
      dec.mapped = rom_addr;
    end
  end

endmodule

[rtl/rom_bank_mapper_with_ram_top.sv]
// latency: a request accepted at one edge has its result offered from the next edge
// throughput: one request per cycle, both registers advance whenever the result is taken
// a stalled result holds the whole pipeline, requests are refused until it is taken
// reset clears the bank register, the configuration and the ram written flags
// the rom image is not cleared and must be loaded before use
module rom_bank_mapper_with_ram_top import rbm_pkg::*; #(
  parameter int ROM_BYTES = 32768
) (
  input  logic               clk,
  input  logic               rst,
  rbm_in_if.sink             access,
  rbm_out_if.source          result,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [CfgW-1:0]    wr_data
);

  localparam int RomAW = $clog2(ROM_BYTES);

  rbm_cfg_t          cfg;
  logic [BankW-1:0]  active_bank;
  logic [RamBytes-1:0] ram_written;

  logic              advance;
  logic              s1_valid;
  rbm_in_t           s1_req;
  rbm_dec_t          dec;

  logic              s2_valid;
  logic              s2_drive;
  logic              s2_use_rom;
  logic              s2_use_ram;
  logic [MapW-1:0]   s2_mapped;
  logic [DataW-1:0]  rom_q;
  logic [DataW-1:0]  ram_q;

  assign advance      = !s2_valid || result.ready;
  assign access.ready = advance;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.narrow_mask  <= 1'b0;
      cfg.bank_count   <= 4'd1;
      cfg.first_strobe <= '0;
      cfg.ram_enable   <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        RegNarrowMask:  cfg.narrow_mask  <= wr_data[0];
        RegBankCount:   cfg.bank_count   <= wr_data[CountW-1:0];
        RegFirstStrobe: cfg.first_strobe <= wr_data[LocW-1:0];
        RegRamEnable:   cfg.ram_enable   <= wr_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= access.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req <= access.data;
    end
  end

  rbm_decode #(
    .ROM_BYTES (ROM_BYTES)
  ) u_decode (
    .valid       (s1_valid),
    .req         (s1_req),
    .cfg         (cfg),
    .active_bank (active_bank),
    .dec         (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= '0;
      ram_written <= '0;
    end else if (advance) begin
      if (dec.bank_we) begin
        active_bank <= dec.new_bank;
      end
      if (dec.ram_we) begin
        ram_written[dec.ram_addr] <= 1'b1;
      end
    end
  end

  rbm_ram #(
    .WIDTH (DataW),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk   (clk),
    .we    (advance && dec.rom_we),
    .waddr (s1_req.load_index[RomAW-1:0]),
    .wdata (s1_req.data_in),
    .re    (advance && dec.rom_re),
    .raddr (dec.mapped[RomAW-1:0]),
    .rdata (rom_q)
  );

  rbm_ram #(
    .WIDTH (DataW),
    .DEPTH (RamBytes)
  ) u_scratch (
    .clk   (clk),
    .we    (advance && dec.ram_we),
    .waddr (dec.ram_addr),
    .wdata (s1_req.data_in),
    .re    (advance && dec.ram_re),
    .raddr (dec.ram_addr),
    .rdata (ram_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_drive   <= dec.drive;
      s2_use_rom <= dec.rom_re;
      s2_use_ram <= dec.ram_re && ram_written[dec.ram_addr];
      s2_mapped  <= dec.mapped;
    end
  end

  assign result.valid               = s2_valid;
  assign result.data.drive_data     = s2_drive;
  assign result.data.mapped_address = s2_mapped;
  assign result.data.data_out       = s2_use_rom ? rom_q : (s2_use_ram ? ram_q : '0);

  a_quiet_bus: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.drive_data |-> result.data.data_out == '0)
    else $error("data driven without drive_data");

  a_bank_in_range: assert property (@(posedge clk) disable iff (rst)
    advance && dec.bank_we |=> {1'b0, active_bank} < $past(cfg.bank_count))
    else $error("bank selected beyond bank count");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({dec.rom_we, dec.rom_re, dec.ram_we, dec.ram_re, dec.bank_we}))
    else $error("more than one memory action per request");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && (s1_req.op == OpLoad) |=> (s2_mapped == '0) && !s2_drive)
    else $error("load produced a non-zero result");

endmodule
